// ===== hdl/chacha20_stream_xor_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef CHACHA20_STREAM_XOR_TOP_MACROS_SVH
`define CHACHA20_STREAM_XOR_TOP_MACROS_SVH
`define CSX_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CSX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hdl/csx_pkg.sv =====
package csx_pkg;
   localparam int unsigned DoubleRoundsDefault = 10;
   localparam int unsigned DataWidth = 64;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth = 64;
   localparam logic [31:0] Sigma0 = 32'h61707865;
   localparam logic [31:0] Sigma1 = 32'h3320646e;
   localparam logic [31:0] Sigma2 = 32'h79622d32;
   localparam logic [31:0] Sigma3 = 32'h6b206574;

   typedef enum logic [2:0] {
      CSR_KEY0 = 3'd0,
      CSR_KEY1 = 3'd1,
      CSR_KEY2 = 3'd2,
      CSR_KEY3 = 3'd3,
      CSR_NONCE_LOW = 3'd4,
      CSR_NONCE_HIGH = 3'd5
   } csr_index_type;

   typedef logic [31:0] state_type [16];

   // Job handed from the front part to the keystream engine.
   typedef struct packed {
      logic [63:0] data_in;
      logic [3:0]  byte_count;
      logic        need_block;
      logic [31:0] block_counter;
      logic [2:0]  word_position;
   } job_type;

   typedef enum logic [1:0] {
      ENG_IDLE = 2'd0,
      ENG_ROUND = 2'd1,
      ENG_FINAL = 2'd2
   } eng_state_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [127:0] quarter(input logic [127:0] abcd);
      logic [31:0] a, b, c, d;
      begin
         a = abcd[31:0]; b = abcd[63:32]; c = abcd[95:64]; d = abcd[127:96];
         a = a + b; d = rotl(d ^ a, 16);
         c = c + d; b = rotl(b ^ c, 12);
         a = a + b; d = rotl(d ^ a, 8);
         c = c + d; b = rotl(b ^ c, 7);
         quarter = {d, c, b, a};
      end
   endfunction

   function automatic logic [63:0] byte_mask(input logic [3:0] count);
      logic [63:0] m;
      begin
         m = '0;
         for (int i = 0; i < 8; i++) begin
            if (count > 4'(i)) m[i*8 +: 8] = 8'hff;
         end
         byte_mask = m;
      end
   endfunction
endpackage

// ===== hdl/csx_if.sv =====
interface csx_if #(parameter int unsigned Width = 1);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/csx_front.sv =====
// Tracks the block counter and word position per accepted word and
// pushes a job into a two-entry queue.
module csx_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [63:0]        data_in,
   input  logic [3:0]         byte_count,
   input  logic               start_message,
   output logic               job_valid,
   input  logic               job_ready,
   output csx_pkg::job_type   job
);
   csx_pkg::job_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [31:0] ctr_ff, ctr_in;
   logic [2:0]  pos_ff, pos_in;
   logic        bvalid_ff, bvalid_in;
   logic        push, pop;
   csx_pkg::job_type new_job;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_ready;
   assign job = q_ff[rd_ff];

   always_comb begin
      logic [31:0] c;
      logic [2:0]  p;
      logic        v;
      c = start_message ? 32'd0 : ctr_ff;
      p = start_message ? 3'd0 : pos_ff;
      v = start_message ? 1'b0 : bvalid_ff;
      new_job.data_in = data_in;
      new_job.byte_count = byte_count;
      new_job.need_block = !v;
      new_job.block_counter = c;
      new_job.word_position = p;
      ctr_in = ctr_ff; pos_in = pos_ff; bvalid_in = bvalid_ff;
      if (push) begin
         pos_in = p + 3'd1;
         if (p == 3'd7) begin
            ctr_in = c + 32'd1;
            bvalid_in = 1'b0;
         end else begin
            ctr_in = c;
            bvalid_in = 1'b1;
         end
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in = rd_ff ^ pop;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
         ctr_ff <= '0; pos_ff <= '0; bvalid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; rd_ff <= rd_in; wr_ff <= wr_in;
         ctr_ff <= ctr_in; pos_ff <= pos_in; bvalid_ff <= bvalid_in;
      end
      if (push) q_ff[wr_ff] <= new_job;
   end
endmodule

// ===== hdl/csx_back.sv =====
// Keystream engine: one double round per cycle, then the feed-forward add,
// then XOR of the selected keystream word into the output register.
module csx_back #(
   parameter int unsigned DoubleRounds = csx_pkg::DoubleRoundsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [255:0]     key,
   input  logic [95:0]      nonce,
   input  logic             job_valid,
   output logic             job_ready,
   input  csx_pkg::job_type job,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [63:0]      data_out,
   output logic [3:0]       valid_bytes
);
   localparam int unsigned RoundBits = $clog2(DoubleRounds + 1);

   csx_pkg::eng_state_type state_ff, state_in;
   logic [31:0] init_ff [16];
   logic [31:0] x_ff [16];
   logic [31:0] x_in [16];
   logic [63:0] ks_ff [8];
   logic [RoundBits-1:0] rnd_ff, rnd_in;
   logic        ov_ff, ov_in;
   logic [63:0] dout_ff;
   logic [3:0]  vb_ff;
   logic        served_ff;
   logic        out_free, deliver, start_gen;
   logic [31:0] init_w [16];
   logic [63:0] ks_word;

   assign out_free = !ov_ff || out_ready;
   assign deliver = job_valid && (!job.need_block || served_ff)
                    && state_ff == csx_pkg::ENG_IDLE && out_free;
   assign start_gen = job_valid && job.need_block && !served_ff
                      && state_ff == csx_pkg::ENG_IDLE;
   assign job_ready = deliver;
   assign ks_word = ks_ff[job.word_position];

   always_comb begin
      init_w[0] = csx_pkg::Sigma0; init_w[1] = csx_pkg::Sigma1;
      init_w[2] = csx_pkg::Sigma2; init_w[3] = csx_pkg::Sigma3;
      for (int i = 0; i < 8; i++) init_w[4 + i] = key[i*32 +: 32];
      init_w[12] = job.block_counter;
      for (int i = 0; i < 3; i++) init_w[13 + i] = nonce[i*32 +: 32];
   end

   // Column quarter rounds, then diagonal quarter rounds.
   always_comb begin
      logic [31:0] y [16];
      logic [127:0] r;
      for (int i = 0; i < 16; i++) y[i] = x_ff[i];
      for (int i = 0; i < 4; i++) begin
         r = csx_pkg::quarter({y[12+i], y[8+i], y[4+i], y[i]});
         {y[12+i], y[8+i], y[4+i], y[i]} = r;
      end
      for (int i = 0; i < 4; i++) begin
         r = csx_pkg::quarter({y[12 + (i+3)%4], y[8 + (i+2)%4], y[4 + (i+1)%4], y[i]});
         {y[12 + (i+3)%4], y[8 + (i+2)%4], y[4 + (i+1)%4], y[i]} = r;
      end
      for (int i = 0; i < 16; i++) x_in[i] = y[i];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csx_pkg::ENG_IDLE:  if (start_gen) state_in = csx_pkg::ENG_ROUND;
         csx_pkg::ENG_ROUND: if (rnd_ff == RoundBits'(DoubleRounds - 1))
            state_in = csx_pkg::ENG_FINAL;
         csx_pkg::ENG_FINAL: state_in = csx_pkg::ENG_IDLE;
         default:            state_in = csx_pkg::ENG_IDLE;
      endcase
   end

   always_comb begin
      rnd_in = (state_ff == csx_pkg::ENG_ROUND) ? rnd_ff + RoundBits'(1) : '0;
      ov_in = deliver ? 1'b1 : (out_ready ? 1'b0 : ov_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csx_pkg::ENG_IDLE; rnd_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rnd_ff <= rnd_in; ov_ff <= ov_in;
      end
      if (start_gen) begin
         for (int i = 0; i < 16; i++) begin
            init_ff[i] <= init_w[i];
            x_ff[i] <= init_w[i];
         end
      end else if (state_ff == csx_pkg::ENG_ROUND) begin
         for (int i = 0; i < 16; i++) x_ff[i] <= x_in[i];
      end
      if (state_ff == csx_pkg::ENG_FINAL) begin
         for (int i = 0; i < 8; i++)
            ks_ff[i] <= {x_ff[2*i+1] + init_ff[2*i+1], x_ff[2*i] + init_ff[2*i]};
      end
      if (deliver) begin
         dout_ff <= (job.data_in ^ ks_word) & csx_pkg::byte_mask(job.byte_count);
         vb_ff <= job.byte_count;
      end
   end

   // A job that asked for a block is served once the block is ready.
   always_ff @(posedge clock) begin
      if (reset) served_ff <= 1'b0;
      else if (state_ff == csx_pkg::ENG_FINAL) served_ff <= 1'b1;
      else if (deliver) served_ff <= 1'b0;
   end

   assign out_valid = ov_ff;
   assign data_out = dout_ff;
   assign valid_bytes = vb_ff;
endmodule

// ===== hdl/chacha20_stream_xor_top.sv =====
// ChaCha20 (IETF) stream XOR engine.
// req channel: one word per handshake: data_in, byte_count, start_message.
// rsp channel: data_out (message XOR keystream, bytes beyond the count zero)
// and valid_bytes. csr port: key words 0-3, nonce low, nonce high, to be
// written while the engine is idle; the block itself does not enforce it.
// A word that continues a block passes through the front queue and then the
// output register. A word that opens a block waits for block generation: the
// state load, the double rounds through the single double-round unit and the
// feed-forward add into the keystream register, then it is delivered.
// Throughput: eight words per block, one word per cycle within a block while
// rsp is not stalled; long messages are limited by the double-round unit.
// Reset clears the counters, queue and output valid flag; the block counter
// restarts at zero. A stalled rsp holds its word; the two-entry front queue
// keeps accepting until full, then req_ready drops.
module chacha20_stream_xor_top #(
   parameter int unsigned DOUBLE_ROUNDS = csx_pkg::DoubleRoundsDefault
) (
   input  logic        clock,
   input  logic        reset,
   csx_if.sink         req,
   csx_if.source       rsp,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   logic [255:0] key_ff;
   logic [95:0]  nonce_ff;
   logic         job_valid, job_ready;
   csx_pkg::job_type job;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0; nonce_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            csx_pkg::CSR_KEY0:       key_ff[63:0] <= csr_write_data;
            csx_pkg::CSR_KEY1:       key_ff[127:64] <= csr_write_data;
            csx_pkg::CSR_KEY2:       key_ff[191:128] <= csr_write_data;
            csx_pkg::CSR_KEY3:       key_ff[255:192] <= csr_write_data;
            csx_pkg::CSR_NONCE_LOW:  nonce_ff[63:0] <= csr_write_data;
            csx_pkg::CSR_NONCE_HIGH: nonce_ff[95:64] <= csr_write_data[31:0];
            default: ;
         endcase
      end
   end

   csx_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .data_in(req.payload[63:0]), .byte_count(req.payload[67:64]),
      .start_message(req.payload[68]),
      .job_valid, .job_ready, .job
   );

   csx_back #(.DoubleRounds(DOUBLE_ROUNDS)) u_back (
      .clock, .reset, .key(key_ff), .nonce(nonce_ff),
      .job_valid, .job_ready, .job,
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .data_out(rsp.payload[63:0]), .valid_bytes(rsp.payload[67:64])
   );
endmodule

// ===== hdl/chacha20_stream_xor_check.sv =====
`include "chacha20_stream_xor_top_macros.svh"
module chacha20_stream_xor_check (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [67:0] rsp_payload
);
   `CSX_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CSX_ASSERT_NEXT(rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))
   `CSX_ASSERT_IMPL(rsp_zero_high, clock, reset,
      rsp_valid && rsp_payload[67:64] == 4'd1, rsp_payload[63:8] == 56'd0)
   `CSX_ASSERT_NEXT(rst_quiet, clock, 1'b0, reset, !rsp_valid)
   `CSX_ASSERT_NEXT(rst_ready, clock, 1'b0, reset, req_ready)
endmodule

bind chacha20_stream_xor_top chacha20_stream_xor_check u_check (
   .clock(clock), .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

// ===== test/testbench.sv =====
module testbench;
   localparam int ReqWidth = csx_pkg::DataWidth + csx_pkg::CountWidth + 1;
   localparam int RspWidth = csx_pkg::DataWidth + csx_pkg::CountWidth;
   localparam int SettleCycles = csx_pkg::DoubleRoundsDefault + 8;

   typedef struct packed {
      logic [3:0]  valid_bytes;
      logic [63:0] data_out;
   } cipher_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_write_data = '0;

   csx_if #(.Width(ReqWidth)) req_ch ();
   csx_if #(.Width(RspWidth)) rsp_ch ();

   chacha20_stream_xor_top DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Shadow copy of the cipher state.
   logic [63:0] key_copy [4];
   logic [63:0] nonce_low_copy;
   logic [31:0] nonce_high_copy;
   logic [31:0] block_number;
   logic [2:0]  word_index;
   logic [63:0] keystream_words [8];
   logic        keystream_loaded;

   cipher_word_type cipher_q [$];
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_left = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   function automatic logic [31:0] rot_left(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void mix(ref logic [31:0] x [16], input int a, input int b,
                               input int c, input int d);
      x[a] = x[a] + x[b]; x[d] = rot_left(x[d] ^ x[a], 16);
      x[c] = x[c] + x[d]; x[b] = rot_left(x[b] ^ x[c], 12);
      x[a] = x[a] + x[b]; x[d] = rot_left(x[d] ^ x[a], 8);
      x[c] = x[c] + x[d]; x[b] = rot_left(x[b] ^ x[c], 7);
   endfunction

   task automatic generate_keystream();
      logic [31:0] init [16];
      logic [31:0] x [16];
      init[0] = 32'h61707865; init[1] = 32'h3320646e;
      init[2] = 32'h79622d32; init[3] = 32'h6b206574;
      for (int k = 0; k < 4; k++) begin
         init[4 + 2*k] = key_copy[k][31:0];
         init[5 + 2*k] = key_copy[k][63:32];
      end
      init[12] = block_number;
      init[13] = nonce_low_copy[31:0];
      init[14] = nonce_low_copy[63:32];
      init[15] = nonce_high_copy;
      x = init;
      for (int r = 0; r < csx_pkg::DoubleRoundsDefault; r++) begin
         mix(x, 0, 4, 8, 12);  mix(x, 1, 5, 9, 13);
         mix(x, 2, 6, 10, 14); mix(x, 3, 7, 11, 15);
         mix(x, 0, 5, 10, 15); mix(x, 1, 6, 11, 12);
         mix(x, 2, 7, 8, 13);  mix(x, 3, 4, 9, 14);
      end
      for (int w = 0; w < 8; w++)
         keystream_words[w] = {x[2*w+1] + init[2*w+1], x[2*w] + init[2*w]};
      keystream_loaded = 1'b1;
   endtask

   task automatic predict_cipher(input logic [63:0] data, input logic [3:0] count,
                                 input logic start);
      cipher_word_type exp_word;
      logic [63:0] mask;
      int n;
      if (start) begin
         block_number = '0;
         word_index = '0;
         keystream_loaded = 1'b0;
      end
      if (!keystream_loaded) generate_keystream();
      n = (count > 8) ? 8 : count;
      mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
      exp_word.data_out = (data ^ keystream_words[word_index]) & mask;
      exp_word.valid_bytes = count;
      cipher_q.push_back(exp_word);
      word_index = word_index + 3'd1;
      if (word_index == 0) begin
         block_number = block_number + 32'd1;
         keystream_loaded = 1'b0;
      end
   endtask

   task automatic write_register(input logic [2:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (index)
         csx_pkg::CSR_KEY0:       key_copy[0] = value;
         csx_pkg::CSR_KEY1:       key_copy[1] = value;
         csx_pkg::CSR_KEY2:       key_copy[2] = value;
         csx_pkg::CSR_KEY3:       key_copy[3] = value;
         csx_pkg::CSR_NONCE_LOW:  nonce_low_copy = value;
         csx_pkg::CSR_NONCE_HIGH: nonce_high_copy = value[31:0];
         default: ;
      endcase
   endtask

   task automatic send_word(input logic [63:0] data, input logic [3:0] count,
                            input logic start);
      req_ch.payload = {start, count, data};
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      predict_cipher(data, count, start);
      words_sent++;
      @(negedge clock);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
   endtask

   // Called at a falling edge, so the last word is withdrawn before the next rise.
   task automatic drain();
      req_ch.valid = 1'b0;
      while (cipher_q.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3,
                           input logic [63:0] nl, input logic [63:0] nh);
      write_register(csx_pkg::CSR_KEY0, k0);
      write_register(csx_pkg::CSR_KEY1, k1);
      write_register(csx_pkg::CSR_KEY2, k2);
      write_register(csx_pkg::CSR_KEY3, k3);
      write_register(csx_pkg::CSR_NONCE_LOW, nl);
      write_register(csx_pkg::CSR_NONCE_HIGH, nh);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cipher_word_type got;
      cipher_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (cipher_q.size() == 0) begin
            $display("%0t: unexpected word %h/%0d", $time, got.data_out, got.valid_bytes);
            errors++;
         end else begin
            want = cipher_q.pop_front();
            words_checked++;
            if (got.data_out !== want.data_out) begin
               $display("%0t: data_out expected %h actual %h",
                        $time, want.data_out, got.data_out);
               errors++;
            end
            if (got.valid_bytes !== want.valid_bytes) begin
               $display("%0t: valid_bytes expected %0d actual %0d",
                        $time, want.valid_bytes, got.valid_bytes);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      // Zero key and nonce first, then extremes of every field and count.
      for (int i = 0; i < 10; i++)
         send_word(i[0] ? '1 : '0, 4'd8, i == 0);
      send_word(64'h0123456789abcdef, 4'd0, 1'b0);
      send_word('1, 4'd9, 1'b0);
      send_word('1, 4'd15, 1'b0);
      send_word(64'haaaaaaaaaaaaaaaa, 4'd3, 1'b0);
      send_word(64'h5555555555555555, 4'd1, 1'b1);
      drain();
      load_key('1, '1, '1, '1, '1, 64'hffffffff);
      write_register(3'd6, rand64());
      write_register(3'd7, rand64());
      for (int c = 0; c < 9; c++)
         send_word(rand64(), c[3:0] == 0 ? 4'd8 : c[3:0], c == 0);
      drain();
      // New key mid-message: the rest of the current block keeps the old keystream, without a restart.
      load_key(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      send_word(rand64(), 4'd8, 1'b0);
      send_word(rand64(), 4'd7, 1'b0);
      drain();
   endtask

   task automatic test_random(input int words, input int idle_pct, input int stall_pct);
      int sent;
      int len;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(9) == 0) begin
            send_word(rand64(), 4'($urandom_range(15)), 1'($urandom_range(1)));
            sent++;
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
            for (int i = 0; i < len; i++)
               send_word(rand64(), (i == len - 1) ? 4'($urandom_range(8, 1)) : 4'd8,
                         i == 0 && $urandom_range(7) != 0);
            sent += len;
         end
      end
      drain();
   endtask

   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      @(negedge clock);
      hold_left = 300;
      for (int i = 0; i < 40; i++)
         send_word(rand64(), 4'd8, i == 0);
      drain();
   endtask

   initial begin
      for (int k = 0; k < 4; k++) key_copy[k] = '0;
      nonce_low_copy = '0;
      nonce_high_copy = '0;
      block_number = '0;
      word_index = '0;
      keystream_loaded = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      load_key(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      test_random(420, 0, 0);
      load_key('0, '0, '0, '0, '1, '0);
      test_random(420, 47, 0);
      load_key(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      test_random(420, 0, 47);
      load_key('1, '0, '1, '0, '0, 64'hffffffff);
      test_random(420, 18, 18);
      test_backpressure();
      $display("Sent %0d words and checked %0d cipher words over several keys,",
               words_sent, words_checked);
      $display("idle and stall mixes, a long receiver hold-off and odd byte counts.");
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("Timeout with %0d words outstanding", cipher_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/csx_pkg.sv
hdl/csx_if.sv
hdl/csx_front.sv
hdl/csx_back.sv
hdl/chacha20_stream_xor_top.sv
hdl/chacha20_stream_xor_check.sv
test/testbench.sv
